FILE: src/tsnb_pkg.sv
package tsnb_pkg;

   // Defaults for the top-level parameters.
   localparam int TEXEL_DEPTH_DEF     = 65536;
   localparam int COORD_FRAC_BITS_DEF = 16;

   // Fixed field widths.
   localparam int COORD_W       = 18;
   localparam int INDEX_W       = 16;
   localparam int CHAN_W        = 8;
   localparam int OUT_W         = 16;
   localparam int SIZE_W        = 9;
   localparam int TEXEL_COORD_W = 8;
   localparam int ROW_BASE_W    = 16;
   localparam int MODE_W        = 2;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 9;

   // Largest texture edge in texels.
   localparam logic [SIZE_W-1:0] SIZE_MAX = 9'd256;

   // Operation codes of a request.
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // Filter mode codes.
   localparam logic [MODE_W-1:0] FILTER_NEAREST  = 2'd0;
   localparam logic [MODE_W-1:0] FILTER_BILINEAR = 2'd1;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_TEX_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEX_HEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_MODE = 2'd2;

   // Slots of the result queue.
   localparam int RSP_FIFO_DEPTH = 4;

   // Texel write payload carried down the pipeline.
   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
   } tsnb_write_type;

   // Control flags of one item between the coordinate stages and the fetch sequencer.
   typedef struct packed {
      logic is_write;
      logic four_taps;
      logic black;
   } tsnb_ctl_type;

   // One sampled color.
   typedef struct packed {
      logic [OUT_W-1:0] red;
      logic [OUT_W-1:0] green;
      logic [OUT_W-1:0] blue;
   } tsnb_rgb_type;

endpackage

FILE: src/tsnb_req_if.sv
interface tsnb_req_if;
   import tsnb_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      op;
   logic [INDEX_W-1:0]        texel_index;
   logic [CHAN_W-1:0]         texel_red;
   logic [CHAN_W-1:0]         texel_green;
   logic [CHAN_W-1:0]         texel_blue;
   logic signed [COORD_W-1:0] coord_u;
   logic signed [COORD_W-1:0] coord_v;

   modport source (
      output valid, op, texel_index, texel_red, texel_green, texel_blue, coord_u, coord_v,
      input  ready
   );

   modport sink (
      input  valid, op, texel_index, texel_red, texel_green, texel_blue, coord_u, coord_v,
      output ready
   );

endinterface

FILE: src/tsnb_rsp_if.sv
interface tsnb_rsp_if;
   import tsnb_pkg::*;

   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] out_red;
   logic [OUT_W-1:0] out_green;
   logic [OUT_W-1:0] out_blue;

   modport source (
      output valid, out_red, out_green, out_blue,
      input  ready
   );

   modport sink (
      input  valid, out_red, out_green, out_blue,
      output ready
   );

endinterface

FILE: src/tsnb_coord.sv
module tsnb_coord #(
   parameter int COORD_FRAC_BITS = tsnb_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic                                  in_op,
   input  tsnb_pkg::tsnb_write_type              in_wr,
   input  logic [COORD_FRAC_BITS:0]              in_u,
   input  logic [COORD_FRAC_BITS:0]              in_v,
   input  logic [tsnb_pkg::SIZE_W-1:0]           tex_w,
   input  logic [tsnb_pkg::SIZE_W-1:0]           tex_h,
   input  logic [tsnb_pkg::MODE_W-1:0]           mode,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output tsnb_pkg::tsnb_ctl_type                out_ctl,
   output tsnb_pkg::tsnb_write_type              out_wr,
   output logic [tsnb_pkg::TEXEL_COORD_W-1:0]    out_fcol,
   output logic [tsnb_pkg::TEXEL_COORD_W-1:0]    out_ccol,
   output logic [tsnb_pkg::ROW_BASE_W-1:0]       out_base0,
   output logic [tsnb_pkg::ROW_BASE_W-1:0]       out_base1,
   output logic [COORD_FRAC_BITS-1:0]            out_wu,
   output logic [COORD_FRAC_BITS-1:0]            out_wv
);
   import tsnb_pkg::*;

   localparam int F  = COORD_FRAC_BITS;
   localparam int CW = F + 1;
   localparam int PW = F + 9;
   localparam logic [PW-1:0] HALF = PW'(1) << (F - 1);

   // Per-axis mapping signals, axis 0 is U and axis 1 is V.
   logic [CW-1:0]            crd [2];
   logic [SIZE_W-1:0]        size [2];
   logic [SIZE_W-1:0]        lim [2];
   logic [SIZE_W-1:0]        mult_op [2];
   logic [PW-1:0]            scaled [2];
   logic [SIZE_W-1:0]        ipart [2];
   logic [F-1:0]             frac [2];
   logic [SIZE_W:0]          up [2];
   logic [TEXEL_COORD_W-1:0] fl [2];
   logic [TEXEL_COORD_W-1:0] ce [2];
   logic                     nearest;
   logic                     bilinear;
   tsnb_ctl_type             ctl;

   // Scaling stage registers.
   logic                     s2_valid_ff, s2_valid_in;
   tsnb_ctl_type             s2_ctl_ff;
   tsnb_write_type           s2_wr_ff;
   logic [TEXEL_COORD_W-1:0] s2_fcol_ff, s2_ccol_ff, s2_frow_ff, s2_crow_ff;
   logic [F-1:0]             s2_wu_ff, s2_wv_ff;

   // Row base stage registers.
   logic                     s3_valid_ff, s3_valid_in;
   logic                     s3_ready;
   tsnb_ctl_type             s3_ctl_ff;
   tsnb_write_type           s3_wr_ff;
   logic [TEXEL_COORD_W-1:0] s3_fcol_ff, s3_ccol_ff;
   logic [ROW_BASE_W-1:0]    s3_base0_ff, s3_base1_ff;
   logic [F-1:0]             s3_wu_ff, s3_wv_ff;

   // Handshake between the two stages.
   assign s3_ready    = !s3_valid_ff || out_ready;
   assign in_ready    = !s2_valid_ff || s3_ready;
   assign s2_valid_in = in_ready ? in_valid : s2_valid_ff;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;

   // Scale each coordinate to texel space and find the floor and ceiling texels.
   always_comb begin
      nearest  = (mode == FILTER_NEAREST);
      bilinear = (mode == FILTER_BILINEAR);
      crd[0]   = in_u;
      crd[1]   = in_v;
      size[0]  = tex_w;
      size[1]  = tex_h;
      for (int k = 0; k < 2; k++) begin
         lim[k]     = size[k] - 9'd1;
         mult_op[k] = nearest ? lim[k] : size[k];
         scaled[k]  = PW'(crd[k]) * PW'(mult_op[k]) + (nearest ? HALF : '0);
         ipart[k]   = scaled[k][PW-1:F];
         frac[k]    = bilinear ? scaled[k][F-1:0] : '0;
         up[k]      = {1'b0, ipart[k]} + (SIZE_W+1)'(frac[k] != '0);
         fl[k]      = (ipart[k] > lim[k]) ? lim[k][TEXEL_COORD_W-1:0]
                                          : ipart[k][TEXEL_COORD_W-1:0];
         ce[k]      = (up[k] > {1'b0, lim[k]}) ? lim[k][TEXEL_COORD_W-1:0]
                                               : up[k][TEXEL_COORD_W-1:0];
      end
      ctl.is_write  = (in_op == OP_WRITE);
      ctl.four_taps = bilinear;
      ctl.black     = !nearest && !bilinear;
   end

   // Control state of both stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // Scaling stage payload.
   always_ff @(posedge clock) begin
      if (in_ready) begin
         s2_ctl_ff  <= ctl;
         s2_wr_ff   <= in_wr;
         s2_fcol_ff <= fl[0];
         s2_ccol_ff <= ce[0];
         s2_frow_ff <= fl[1];
         s2_crow_ff <= ce[1];
         s2_wu_ff   <= frac[0];
         s2_wv_ff   <= frac[1];
      end
   end

   // Row base stage payload: the row offsets of the floor and ceiling rows.
   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_ctl_ff   <= s2_ctl_ff;
         s3_wr_ff    <= s2_wr_ff;
         s3_fcol_ff  <= s2_fcol_ff;
         s3_ccol_ff  <= s2_ccol_ff;
         s3_base0_ff <= ROW_BASE_W'(17'(s2_frow_ff) * 17'(tex_w));
         s3_base1_ff <= ROW_BASE_W'(17'(s2_crow_ff) * 17'(tex_w));
         s3_wu_ff    <= s2_wu_ff;
         s3_wv_ff    <= s2_wv_ff;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_ctl   = s3_ctl_ff;
   assign out_wr    = s3_wr_ff;
   assign out_fcol  = s3_fcol_ff;
   assign out_ccol  = s3_ccol_ff;
   assign out_base0 = s3_base0_ff;
   assign out_base1 = s3_base1_ff;
   assign out_wu    = s3_wu_ff;
   assign out_wv    = s3_wv_ff;

endmodule

FILE: src/texture_sampler_nearest_bilinear.sv
// Channel   Direction  Transaction
// req_ch    in         texel write (op 0) or sample at U, V (op 1)
// rsp_ch    out        one sampled color in 8.8 per sample, none per write
// csr_*     in         register write: width, height, filter mode
//
// Writes and nearest or unsupported-mode samples use one texel memory access each, one
// transaction per cycle when nothing stalls; a bilinear sample reads its four texels in turn.
// A result passes the input, scaling, row base and fetch stages, the memory read register
// and the product register before it enters the result queue. Reset clears the pipeline
// and registers, not the texel memory. A stalled result waits in a four-entry queue; a new
// sample is held only when every queue slot is already promised to a sample in flight.
module texture_sampler_nearest_bilinear #(
   parameter int TEXEL_DEPTH     = tsnb_pkg::TEXEL_DEPTH_DEF,
   parameter int COORD_FRAC_BITS = tsnb_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   tsnb_req_if.sink                         req_ch,
   tsnb_rsp_if.source                       rsp_ch,
   input  logic                             csr_we,
   input  logic [tsnb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tsnb_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tsnb_pkg::*;

   localparam int F          = COORD_FRAC_BITS;
   localparam int CW         = F + 1;
   localparam int WW         = 2 * F + 1;
   localparam int ACC_W      = 2 * F + 8;
   localparam int ADDR_W     = $clog2(TEXEL_DEPTH);
   localparam int ADDR_EXT_W = ((ADDR_W > INDEX_W) ? ADDR_W : INDEX_W) + 1;
   localparam int TEXEL_W    = 3 * CHAN_W;
   localparam int FP_W       = $clog2(RSP_FIFO_DEPTH);
   localparam int CR_W       = $clog2(RSP_FIFO_DEPTH + 1);

   localparam logic [CW-1:0]         ONE       = CW'(1) << F;
   localparam logic [ACC_W-1:0]      RND       = ACC_W'(1) << (2 * F - 9);
   localparam logic [ADDR_EXT_W-1:0] DEPTH_LIM = ADDR_EXT_W'(TEXEL_DEPTH);

   // Clamp a signed coordinate to the range 0 to 1.0.
   function automatic logic [CW-1:0] clamp_coord(input logic [COORD_W-1:0] raw);
      localparam int CMP_W = (CW > COORD_W - 1) ? CW : COORD_W - 1;
      logic [CMP_W-1:0] mag;
      mag = CMP_W'(raw[COORD_W-2:0]);
      if (raw[COORD_W-1]) begin
         return '0;
      end else if (mag > CMP_W'(ONE)) begin
         return ONE;
      end else begin
         return CW'(mag);
      end
   endfunction

   // Configuration registers.
   logic [SIZE_W-1:0] tex_width_ff, tex_height_ff;
   logic [MODE_W-1:0] filter_mode_ff;
   logic [SIZE_W-1:0] w_eff, h_eff;

   // Input stage.
   logic           s1_valid_ff, s1_valid_in;
   logic           s1_op_ff;
   tsnb_write_type s1_wr_ff;
   logic [CW-1:0]  s1_u_ff, s1_v_ff;

   // Coordinate stages output.
   logic                     crd_in_ready;
   logic                     crd_valid;
   tsnb_ctl_type             crd_ctl;
   tsnb_write_type           crd_wr;
   logic [TEXEL_COORD_W-1:0] crd_fcol, crd_ccol;
   logic [ROW_BASE_W-1:0]    crd_base0, crd_base1;
   logic [F-1:0]             crd_wu, crd_wv;

   // Fetch sequencer.
   logic                     s4_valid_ff, s4_valid_in;
   logic [1:0]               slot_ff, slot_in;
   tsnb_ctl_type             s4_ctl_ff;
   tsnb_write_type           s4_wr_ff;
   logic [TEXEL_COORD_W-1:0] s4_fcol_ff, s4_ccol_ff;
   logic [ROW_BASE_W-1:0]    s4_base0_ff, s4_base1_ff;
   logic [F-1:0]             s4_wu_ff, s4_wv_ff;
   logic                     s4_take;
   logic                     go;
   logic                     last;
   logic                     start_sample;
   logic [TEXEL_COORD_W-1:0] col;
   logic [ROW_BASE_W-1:0]    base;
   logic [ADDR_EXT_W-1:0]    addr_ext;
   logic                     in_range;
   logic [CW-1:0]            wx, wy;
   logic [WW-1:0]            weight;

   // Texel memory port.
   logic [TEXEL_W-1:0] texel_mem [TEXEL_DEPTH];
   logic [ADDR_W-1:0]  mem_addr;
   logic               mem_we;
   logic [TEXEL_W-1:0] mem_rdata_ff;

   // Read return and blend pipeline.
   logic             r_valid_ff, r_first_ff, r_last_ff, r_zero_ff;
   logic [WW-1:0]    r_weight_ff;
   logic [ACC_W-1:0] prod_in [3];
   logic             p_valid_ff, p_first_ff, p_last_ff;
   logic [ACC_W-1:0] p_prod_ff [3];
   logic [ACC_W-1:0] acc_ff [3];
   logic [ACC_W-1:0] acc_sum [3];

   // Result queue and credit count.
   tsnb_rgb_type    fifo_mem [RSP_FIFO_DEPTH];
   tsnb_rgb_type    push_data;
   logic [FP_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CR_W-1:0] count_ff, count_in;
   logic [CR_W-1:0] inflight_ff, inflight_in;
   logic            push, pop;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         tex_width_ff   <= SIZE_MAX;
         tex_height_ff  <= SIZE_MAX;
         filter_mode_ff <= FILTER_NEAREST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TEX_WIDTH:   tex_width_ff   <= csr_wdata;
            CSR_TEX_HEIGHT:  tex_height_ff  <= csr_wdata;
            CSR_FILTER_MODE: filter_mode_ff <= csr_wdata[MODE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // A size of zero acts as one, and a size above the maximum acts as the maximum.
   always_comb begin
      w_eff = (tex_width_ff == '0) ? SIZE_W'(1) :
              (tex_width_ff > SIZE_MAX) ? SIZE_MAX : tex_width_ff;
      h_eff = (tex_height_ff == '0) ? SIZE_W'(1) :
              (tex_height_ff > SIZE_MAX) ? SIZE_MAX : tex_height_ff;
   end

   // Input stage: accept a transaction and clamp its coordinates.
   assign req_ch.ready = !s1_valid_ff || crd_in_ready;
   assign s1_valid_in  = req_ch.ready ? req_ch.valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready) begin
         s1_op_ff       <= req_ch.op;
         s1_wr_ff.index <= req_ch.texel_index;
         s1_wr_ff.red   <= req_ch.texel_red;
         s1_wr_ff.green <= req_ch.texel_green;
         s1_wr_ff.blue  <= req_ch.texel_blue;
         s1_u_ff        <= clamp_coord(req_ch.coord_u);
         s1_v_ff        <= clamp_coord(req_ch.coord_v);
      end
   end

   tsnb_coord #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS)
   ) u_coord (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_ready  (crd_in_ready),
      .in_op     (s1_op_ff),
      .in_wr     (s1_wr_ff),
      .in_u      (s1_u_ff),
      .in_v      (s1_v_ff),
      .tex_w     (w_eff),
      .tex_h     (h_eff),
      .mode      (filter_mode_ff),
      .out_valid (crd_valid),
      .out_ready (s4_take),
      .out_ctl   (crd_ctl),
      .out_wr    (crd_wr),
      .out_fcol  (crd_fcol),
      .out_ccol  (crd_ccol),
      .out_base0 (crd_base0),
      .out_base1 (crd_base1),
      .out_wu    (crd_wu),
      .out_wv    (crd_wv)
   );

   // Fetch sequencer: one memory access per slot, four slots for a bilinear sample.
   // A sample starts only when a result queue slot is free for it.
   always_comb begin
      go           = s4_valid_ff && (s4_ctl_ff.is_write || (slot_ff != 2'd0) ||
                                     (inflight_ff < CR_W'(RSP_FIFO_DEPTH)));
      last         = s4_ctl_ff.is_write || !s4_ctl_ff.four_taps || (slot_ff == 2'd3);
      start_sample = go && !s4_ctl_ff.is_write && (slot_ff == 2'd0);
      s4_take      = !s4_valid_ff || (go && last);
      s4_valid_in  = s4_take ? crd_valid : s4_valid_ff;
      slot_in      = go ? (last ? 2'd0 : slot_ff + 2'd1) : slot_ff;
   end

   // Texel address and corner weight of the current slot.
   always_comb begin
      col      = slot_ff[0] ? s4_ccol_ff : s4_fcol_ff;
      base     = slot_ff[1] ? s4_base1_ff : s4_base0_ff;
      addr_ext = s4_ctl_ff.is_write ? ADDR_EXT_W'(s4_wr_ff.index)
                                    : ADDR_EXT_W'(base) + ADDR_EXT_W'(col);
      in_range = (addr_ext < DEPTH_LIM);
      mem_addr = addr_ext[ADDR_W-1:0];
      mem_we   = go && s4_ctl_ff.is_write && in_range;
      wx       = slot_ff[0] ? CW'(s4_wu_ff) : ONE - CW'(s4_wu_ff);
      wy       = slot_ff[1] ? CW'(s4_wv_ff) : ONE - CW'(s4_wv_ff);
      weight   = WW'(wx) * WW'(wy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         slot_ff     <= 2'd0;
      end else begin
         s4_valid_ff <= s4_valid_in;
         slot_ff     <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_take) begin
         s4_ctl_ff   <= crd_ctl;
         s4_wr_ff    <= crd_wr;
         s4_fcol_ff  <= crd_fcol;
         s4_ccol_ff  <= crd_ccol;
         s4_base0_ff <= crd_base0;
         s4_base1_ff <= crd_base1;
         s4_wu_ff    <= crd_wu;
         s4_wv_ff    <= crd_wv;
      end
   end

   // Single-port texel memory with registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         texel_mem[mem_addr] <= {s4_wr_ff.red, s4_wr_ff.green, s4_wr_ff.blue};
      end
      mem_rdata_ff <= texel_mem[mem_addr];
   end

   // Tag of the texel that returns from memory in the next cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else begin
         r_valid_ff <= go && !s4_ctl_ff.is_write;
      end
   end

   always_ff @(posedge clock) begin
      r_first_ff  <= (slot_ff == 2'd0);
      r_last_ff   <= last;
      r_zero_ff   <= s4_ctl_ff.black || !in_range;
      r_weight_ff <= weight;
   end

   // Weight each channel of the returned texel.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         prod_in[c] = r_zero_ff ? '0
                    : ACC_W'(mem_rdata_ff[(2 - c) * CHAN_W +: CHAN_W]) * ACC_W'(r_weight_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= r_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p_first_ff <= r_first_ff;
      p_last_ff  <= r_last_ff;
      for (int c = 0; c < 3; c++) begin
         p_prod_ff[c] <= prod_in[c];
      end
   end

   // Accumulate the weighted texels; the first one seeds the rounding constant.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         acc_sum[c] = (p_first_ff ? RND : acc_ff[c]) + p_prod_ff[c];
      end
      push_data.red   = acc_sum[0][ACC_W-1 -: OUT_W];
      push_data.green = acc_sum[1][ACC_W-1 -: OUT_W];
      push_data.blue  = acc_sum[2][ACC_W-1 -: OUT_W];
      push            = p_valid_ff && p_last_ff;
   end

   always_ff @(posedge clock) begin
      if (p_valid_ff) begin
         for (int c = 0; c < 3; c++) begin
            acc_ff[c] <= acc_sum[c];
         end
      end
   end

   // Result queue.
   assign pop              = rsp_ch.valid && rsp_ch.ready;
   assign rsp_ch.valid     = (count_ff != '0);
   assign rsp_ch.out_red   = fifo_mem[rd_ptr_ff].red;
   assign rsp_ch.out_green = fifo_mem[rd_ptr_ff].green;
   assign rsp_ch.out_blue  = fifo_mem[rd_ptr_ff].blue;

   always_comb begin
      count_in    = count_ff + CR_W'(push) - CR_W'(pop);
      inflight_in = inflight_ff + CR_W'(start_sample) - CR_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
         inflight_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == FP_W'(RSP_FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + FP_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == FP_W'(RSP_FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + FP_W'(1);
         end
         count_ff    <= count_in;
         inflight_ff <= inflight_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: verif/tb.sv
module tb;
   import tsnb_pkg::*;

   // Filter mode codes that the block does not support; both must give black.
   localparam logic [MODE_W-1:0] FILTER_UNKNOWN_LO = 2'd2;
   localparam logic [MODE_W-1:0] FILTER_UNKNOWN_HI = 2'd3;

   localparam longint unsigned UNIT        = 64'd1 << COORD_FRAC_BITS_DEF;
   localparam int              BLEND_SHIFT = 2 * COORD_FRAC_BITS_DEF - 8;
   localparam int              DRAIN_CYCLES = 16;
   localparam int unsigned     CYCLE_LIMIT  = 400000;

   // Predicts the sampled colors from its own copy of the texel store and registers,
   // and compares each returned color with the oldest prediction.
   class texture_tracker;
      logic [23:0]       texels [TEXEL_DEPTH_DEF];
      bit                filled [TEXEL_DEPTH_DEF];
      logic [SIZE_W-1:0] width_reg;
      logic [SIZE_W-1:0] height_reg;
      logic [MODE_W-1:0] mode_reg;
      int unsigned       tap_addr [4];
      int unsigned       tap_count;
      longint unsigned   frac_u;
      longint unsigned   frac_v;
      tsnb_rgb_type      pending_colors [$];
      int                errors;

      function new();
         width_reg = SIZE_MAX;
         height_reg = SIZE_MAX;
         mode_reg = FILTER_NEAREST;
         errors = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_TEX_WIDTH: width_reg = val;
            CSR_TEX_HEIGHT: height_reg = val;
            CSR_FILTER_MODE: mode_reg = val[MODE_W-1:0];
            default: ;
         endcase
      endfunction

      // A size of zero behaves as one texel, anything above the maximum as the maximum.
      function int unsigned edge_len(logic [SIZE_W-1:0] s);
         if (s == 0) return 1;
         if (s > SIZE_MAX) return SIZE_MAX;
         return s;
      endfunction

      function longint unsigned clamp_coord(logic signed [COORD_W-1:0] c);
         int ci;
         ci = c;
         if (ci < 0) return 0;
         if (ci > int'(UNIT)) return UNIT;
         return ci;
      endfunction

      // Works out the four texel addresses and the blend weights of a sample.
      // Nearest mode uses one texel four times with zero weights, which blends exactly
      // to that texel. Unknown modes read nothing.
      function void plan_taps(logic signed [COORD_W-1:0] cu, logic signed [COORD_W-1:0] cv);
         int unsigned     w;
         int unsigned     h;
         int unsigned     fu;
         int unsigned     fv;
         int unsigned     ceil_u;
         int unsigned     ceil_v;
         longint unsigned u;
         longint unsigned v;
         longint unsigned pu;
         longint unsigned pv;
         w = edge_len(width_reg);
         h = edge_len(height_reg);
         u = clamp_coord(cu);
         v = clamp_coord(cv);
         frac_u = 0;
         frac_v = 0;
         tap_count = 4;
         if (mode_reg == FILTER_NEAREST) begin
            fu = 32'((u * (w - 1) + UNIT / 2) >> COORD_FRAC_BITS_DEF);
            fv = 32'((v * (h - 1) + UNIT / 2) >> COORD_FRAC_BITS_DEF);
            for (int t = 0; t < 4; t++) tap_addr[t] = fv * w + fu;
         end else if (mode_reg == FILTER_BILINEAR) begin
            pu = u * w;
            pv = v * h;
            fu = 32'(pu >> COORD_FRAC_BITS_DEF);
            fv = 32'(pv >> COORD_FRAC_BITS_DEF);
            frac_u = pu & (UNIT - 1);
            frac_v = pv & (UNIT - 1);
            ceil_u = fu + (frac_u != 0);
            ceil_v = fv + (frac_v != 0);
            // At a coordinate of 1.0 the floor texel sits past the edge and is pulled back.
            if (fu > w - 1) fu = w - 1;
            if (fv > h - 1) fv = h - 1;
            if (ceil_u > w - 1) ceil_u = w - 1;
            if (ceil_v > h - 1) ceil_v = h - 1;
            tap_addr[0] = fv * w + fu;
            tap_addr[1] = fv * w + ceil_u;
            tap_addr[2] = ceil_v * w + fu;
            tap_addr[3] = ceil_v * w + ceil_u;
         end else begin
            tap_count = 0;
         end
      endfunction

      // Exact blend of the four taps, rounded half up to 8.8 at the end.
      function tsnb_rgb_type sample_color(logic signed [COORD_W-1:0] cu,
                                          logic signed [COORD_W-1:0] cv);
         tsnb_rgb_type     rgb;
         longint unsigned  ch [4];
         longint unsigned  rf;
         longint unsigned  rc;
         longint unsigned  s;
         logic [OUT_W-1:0] o [3];
         plan_taps(cu, cv);
         if (tap_count == 0) return '0;
         for (int c = 0; c < 3; c++) begin
            for (int t = 0; t < 4; t++) ch[t] = (texels[tap_addr[t]] >> (16 - 8 * c)) & 24'hFF;
            rf = ch[0] * (UNIT - frac_u) + ch[1] * frac_u;
            rc = ch[2] * (UNIT - frac_u) + ch[3] * frac_u;
            s = rf * (UNIT - frac_v) + rc * frac_v;
            o[c] = OUT_W'((s + (64'd1 << (BLEND_SHIFT - 1))) >> BLEND_SHIFT);
         end
         rgb.red = o[0];
         rgb.green = o[1];
         rgb.blue = o[2];
         return rgb;
      endfunction

      // A write updates the store; a sample queues the color it must return.
      function void note_request(logic op, logic [INDEX_W-1:0] idx,
                                 logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                 logic [CHAN_W-1:0] b,
                                 logic signed [COORD_W-1:0] cu,
                                 logic signed [COORD_W-1:0] cv);
         if (op == OP_WRITE) begin
            texels[idx] = {r, g, b};
            filled[idx] = 1'b1;
         end else begin
            pending_colors.push_back(sample_color(cu, cv));
         end
      endfunction

      function void compare_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_color(logic [OUT_W-1:0] r, logic [OUT_W-1:0] g, logic [OUT_W-1:0] b);
         tsnb_rgb_type want;
         if (pending_colors.size() == 0) begin
            errors++;
            $display("%0t: result with no sample pending, expected none, actual %0d %0d %0d",
                     $time, r, g, b);
            return;
         end
         want = pending_colors.pop_front();
         compare_field("out_red", want.red, r);
         compare_field("out_green", want.green, g);
         compare_field("out_blue", want.blue, b);
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   bit                     no_idle = 1'b0;
   int unsigned            cycle_count = 0;
   int unsigned            sent_count = 0;
   texture_tracker         tracker = new();

   tsnb_req_if req_if ();
   tsnb_rsp_if rsp_if ();

   texture_sampler_nearest_bilinear u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Guard against a hung block.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Result side backpressure.
   always @(posedge clock) begin
      rsp_if.ready <= no_idle || ($urandom_range(0, 99) >= 18);
   end

   // Handshake signals are stable at the falling edge; a transaction seen here
   // completes at the next rising edge.
   always @(negedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         tracker.check_color(rsp_if.out_red, rsp_if.out_green, rsp_if.out_blue);
      end
   end

   // Drive one request transaction, with random idle cycles ahead of it unless no_idle is set.
   task automatic send_req(logic op, logic [INDEX_W-1:0] idx, logic [CHAN_W-1:0] r,
                           logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b,
                           logic signed [COORD_W-1:0] u, logic signed [COORD_W-1:0] v);
      if (!no_idle) begin
         while ($urandom_range(0, 99) < 18) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_if.valid <= 1'b1;
      req_if.op <= op;
      req_if.texel_index <= idx;
      req_if.texel_red <= r;
      req_if.texel_green <= g;
      req_if.texel_blue <= b;
      req_if.coord_u <= u;
      req_if.coord_v <= v;
      do @(negedge clock); while (!req_if.ready);
      @(posedge clock);
      tracker.note_request(op, idx, r, g, b, u, v);
      sent_count++;
   endtask

   // A sample preceded by writes to any of its texels that were never loaded.
   task automatic sample_at(logic signed [COORD_W-1:0] u, logic signed [COORD_W-1:0] v);
      tracker.plan_taps(u, v);
      for (int t = 0; t < tracker.tap_count; t++) begin
         if (!tracker.filled[tracker.tap_addr[t]]) begin
            send_req(OP_WRITE, INDEX_W'(tracker.tap_addr[t]), CHAN_W'($urandom),
                     CHAN_W'($urandom), CHAN_W'($urandom), COORD_W'($urandom),
                     COORD_W'($urandom));
         end
      end
      send_req(OP_SAMPLE, INDEX_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
               CHAN_W'($urandom), u, v);
   endtask

   // Stop sending and wait for every sample to return and the pipeline to settle.
   task automatic drain();
      req_if.valid <= 1'b0;
      while (tracker.pending_colors.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      tracker.set_register(idx, val);
   endtask

   task automatic set_config(logic [CSR_DATA_W-1:0] w, logic [CSR_DATA_W-1:0] h,
                             logic [MODE_W-1:0] mode);
      drain();
      csr_write(CSR_TEX_WIDTH, w);
      csr_write(CSR_TEX_HEIGHT, h);
      csr_write(CSR_FILTER_MODE, mode);
      csr_we <= 1'b0;
   endtask

   // Coordinates mostly inside the texture, often on texel boundaries and the ends
   // of the range, sometimes anywhere in the field.
   function automatic logic signed [COORD_W-1:0] pick_coord(int unsigned size);
      int unsigned pick;
      int          k;
      pick = $urandom_range(0, 99);
      if (pick < 55) return COORD_W'($urandom_range(0, 65536));
      if (pick < 75) begin
         k = $urandom_range(0, size);
         return COORD_W'((k * 65536) / int'(size) + int'($urandom_range(0, 2)) - 1);
      end
      if (pick < 85) begin
         case ($urandom_range(0, 3))
            0: return 18'sd0;
            1: return 18'sd1;
            2: return 18'sd65535;
            default: return 18'sd65536;
         endcase
      end
      return COORD_W'($urandom);
   endfunction

   // Sends about count transactions, the texel loads ahead of each sample included.
   task automatic run_random(int unsigned count, bit quiet, bit hold_midway);
      int unsigned w;
      int unsigned h;
      int unsigned first;
      bit          held;
      w = tracker.edge_len(tracker.width_reg);
      h = tracker.edge_len(tracker.height_reg);
      first = sent_count;
      held = 1'b0;
      no_idle = quiet;
      while (sent_count - first < count) begin
         if (hold_midway && !held && (sent_count - first >= count / 2)) begin
            drain();
            held = 1'b1;
         end
         if ($urandom_range(0, 99) < 20) begin
            send_req(OP_WRITE, INDEX_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
                     CHAN_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
         end else begin
            sample_at(pick_coord(w), pick_coord(h));
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.op = OP_WRITE;
      req_if.texel_index = '0;
      req_if.texel_red = '0;
      req_if.texel_green = '0;
      req_if.texel_blue = '0;
      req_if.coord_u = '0;
      req_if.coord_v = '0;
      csr_we = 1'b0;
      csr_index = CSR_TEX_WIDTH;
      csr_wdata = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: full size texture, nearest filtering.
      send_req(OP_WRITE, 16'h0000, 8'h00, 8'hFF, 8'h00, 18'sh00000, 18'sh3FFFF);
      send_req(OP_WRITE, 16'hFFFF, 8'hFF, 8'h00, 8'hFF, 18'sh1FFFF, 18'sh20000);
      sample_at(-18'sd131072, -18'sd131072);
      sample_at(18'sd131071, 18'sd131071);
      sample_at(18'sd0, 18'sd65536);
      sample_at(18'sd32768, 18'sd32767);

      // Bilinear at full size, including coordinates of exactly 1.0.
      set_config(9'd256, 9'd256, FILTER_BILINEAR);
      sample_at(18'sd65536, 18'sd65536);
      sample_at(18'sd65535, 18'sd1);
      sample_at(-18'sd5, 18'sd70000);

      // Size registers outside the legal range, and a one-texel texture.
      set_config(9'd0, 9'd511, FILTER_BILINEAR);
      sample_at(18'sd65536, 18'sd32768);
      sample_at(18'sd0, 18'sd0);
      set_config(9'd300, 9'd0, FILTER_NEAREST);
      sample_at(18'sd65536, -18'sd1);
      sample_at(18'sd32768, 18'sd0);
      set_config(9'd1, 9'd1, FILTER_BILINEAR);
      sample_at(18'sd12345, 18'sd54321);

      // Unsupported modes return black.
      set_config(9'd3, 9'd4, FILTER_UNKNOWN_LO);
      sample_at(18'sd65536, 18'sd65536);
      set_config(9'd3, 9'd4, FILTER_UNKNOWN_HI);
      sample_at(18'sd0, 18'sd0);

      // Random traffic under a range of settings.
      set_config(9'd256, 9'd256, FILTER_BILINEAR);
      run_random(70, 1'b0, 1'b0);
      set_config(9'd7, 9'd9, FILTER_BILINEAR);
      run_random(70, 1'b1, 1'b0);
      set_config(9'd16, 9'd16, FILTER_BILINEAR);
      run_random(80, 1'b0, 1'b1);
      set_config(9'd5, 9'd3, FILTER_NEAREST);
      run_random(60, 1'b0, 1'b0);
      set_config(9'd13, 9'd6, FILTER_UNKNOWN_HI);
      run_random(30, 1'b0, 1'b0);
      set_config(9'd2, 9'd256, FILTER_BILINEAR);
      run_random(60, 1'b0, 1'b0);
      set_config(9'd256, 9'd2, FILTER_NEAREST);
      run_random(60, 1'b0, 1'b0);
      set_config(9'd31, 9'd17, FILTER_BILINEAR);
      run_random(70, 1'b0, 1'b0);
      set_config(9'd1, 9'd200, FILTER_NEAREST);
      run_random(40, 1'b0, 1'b0);
      set_config(9'd300, 9'd5, FILTER_BILINEAR);
      run_random(50, 1'b0, 1'b0);
      set_config(9'd0, 9'd0, FILTER_BILINEAR);
      run_random(30, 1'b0, 1'b0);
      set_config(9'd64, 9'd64, FILTER_NEAREST);
      run_random(60, 1'b0, 1'b0);

      drain();
      if (tracker.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
